>>> sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial-division prime test block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

  // width of the result stream data bus (prime flag, zero filled to a byte)
  localparam int OUT_TDATA_W = 8;

  // status returned by the remainder unit to the sequencer
  typedef struct packed {
    logic done;      // one-cycle pulse, remainder is final
    logic rem_zero;  // remainder of the last division is zero
  } tdpt_div_stat_t;

endpackage

`default_nettype wire

>>> sv/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Reports whether each signed input value is prime by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per value, in_tdata holds number (VALUE_WIDTH bits,
//           two's complement, zero filled to whole bytes).
//   out_* : one result per request, out_tdata[0] is the prime flag.
//   Negatives, 0 and 1 skip the trials and go straight to the result.
//   Otherwise divisors 2, 3, 5, 7, ... are tried while d*d <= n. Each trial
//   runs through the bit-serial remainder unit, one dividend bit per cycle.
//   Worst case about sqrt(n)/2 divisors are tried, near 23170 trials for a
//   large 32-bit prime.
//   One request is worked on at a time; in_tready is high only when idle.
//   A finished result sits in the output register; a new request is taken
//   while it waits, and its own result holds until the first is taken.
//   Synchronous active-low reset returns the block to idle with no result
//   pending.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [VALUE_WIDTH-1:0] number
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] prime
  output logic [OUT_TDATA_W-1:0]                out_tdata
);

  localparam int DW = VALUE_WIDTH / 2 + 1;  // divisor width
  localparam int SW = VALUE_WIDTH + 1;      // divisor square width

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [SW-1:0]          sq_r, sq_nxt;
  logic                   res_r, res_nxt;
  logic                   ov_r, ov_nxt;
  logic                   op_r, op_nxt;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] in_val;
  tdpt_div_stat_t         div_stat;

  assign in_val = in_tdata[VALUE_WIDTH-1:0];

  // shared remainder unit
  tdpt_divider #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIV_WIDTH  (DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(n_r),
    .divisor (d_r),
    .stat    (div_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    op_nxt    = op_r;
    div_start = 1'b0;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt  = in_val;
          d_nxt  = DW'(2);
          sq_nxt = SW'(4);
          if (in_val[VALUE_WIDTH-1] || (in_val < VALUE_WIDTH'(2))) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > {1'b0, n_r}) begin
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            // next odd divisor, square updated as (d+2)^2 = d^2 + 4d + 4
            if (d_r == DW'(2)) begin
              d_nxt  = DW'(3);
              sq_nxt = SW'(9);
            end else begin
              d_nxt  = d_r + DW'(2);
              sq_nxt = sq_r + SW'({d_r, 2'b00}) + SW'(4);
            end
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FIN: begin
        // load result once the output register is free
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          op_nxt    = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
    op_r  <= op_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, op_r};

endmodule

`default_nettype wire

>>> sv/tdpt_divider.sv
// ----------------------------------------------------------------------------
// tdpt_divider
// Bit-serial restoring remainder unit: one dividend bit per cycle, with one
// shared subtract and compare, one pass over all VALUE_WIDTH bits per division.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_divider
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int DIV_WIDTH   = 17
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [DIV_WIDTH-1:0]   divisor,
  output tdpt_div_stat_t              stat
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic                   run_r, run_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic [DIV_WIDTH-1:0]   rem_r, rem_nxt;
  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH:0]     diff;

  // shift in next dividend bit and try the subtraction
  assign trial = {rem_r, sh_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      sh_nxt  = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      sh_nxt = {sh_r[VALUE_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[DIV_WIDTH-1:0];
      end else begin
        rem_nxt = trial[DIV_WIDTH-1:0];
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(VALUE_WIDTH - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

`default_nettype wire
